>>> hw/rtl/sha2_family_hash_assert.svh
// Assertion macros used by the checker file.
`ifndef SHA2_FAMILY_HASH_ASSERT_SVH
`define SHA2_FAMILY_HASH_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SHA2FH_ASSERT_NOW(name, clk, rstn, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("%m: assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define SHA2FH_ASSERT_NEXT(name, clk, rstn, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("%m: assertion failed");

`endif

>>> hw/rtl/sha2fh_pkg.sv
`default_nettype none
package sha2fh_pkg;

  localparam logic [2:0] VarSha224    = 3'd0;
  localparam logic [2:0] VarSha256    = 3'd1;
  localparam logic [2:0] VarSha512224 = 3'd5;
  localparam logic [2:0] VarLast      = 3'd5;
  localparam logic [7:0] PadMark      = 8'h80;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_ROUND,
    ST_FOLD,
    ST_OUT
  } state_e;

  typedef enum logic [1:0] {
    SEL_MSG,
    SEL_MARK,
    SEL_PAD
  } byte_sel_e;

  typedef struct packed {
    logic      absorb;
    byte_sel_e sel;
    logic      len_zone;
    logic      count;
    logic      round;
    logic      fold;
    logic      out_adv;
    logic      restart;
  } cmd_t;

  typedef struct packed {
    logic fill_last;
    logic at_len;
    logic round_last;
    logic out_last;
  } sts_t;

  function automatic logic [63:0] iv_word(input logic [2:0] v, input logic [2:0] i);
    logic [63:0] r384;
    logic [63:0] r512;
    logic [63:0] r256;
    logic [63:0] r224;
    logic [63:0] res;
    unique case (i)
      3'd0: begin
        r384 = 64'hcbbb9d5dc1059ed8; r512 = 64'h6a09e667f3bcc908;
        r256 = 64'h22312194fc2bf72c; r224 = 64'h8c3d37c819544da2;
      end
      3'd1: begin
        r384 = 64'h629a292a367cd507; r512 = 64'hbb67ae8584caa73b;
        r256 = 64'h9f555fa3c84c64c2; r224 = 64'h73e1996689dcd4d6;
      end
      3'd2: begin
        r384 = 64'h9159015a3070dd17; r512 = 64'h3c6ef372fe94f82b;
        r256 = 64'h2393b86b6f53b151; r224 = 64'h1dfab7ae32ff9c82;
      end
      3'd3: begin
        r384 = 64'h152fecd8f70e5939; r512 = 64'ha54ff53a5f1d36f1;
        r256 = 64'h963877195940eabd; r224 = 64'h679dd514582f9fcf;
      end
      3'd4: begin
        r384 = 64'h67332667ffc00b31; r512 = 64'h510e527fade682d1;
        r256 = 64'h96283ee2a88effe3; r224 = 64'h0f6d2b697bd44da8;
      end
      3'd5: begin
        r384 = 64'h8eb44a8768581511; r512 = 64'h9b05688c2b3e6c1f;
        r256 = 64'hbe5e1e2553863992; r224 = 64'h77e36f7304c48942;
      end
      3'd6: begin
        r384 = 64'hdb0c2e0d64f98fa7; r512 = 64'h1f83d9abfb41bd6b;
        r256 = 64'h2b0199fc2c85b8aa; r224 = 64'h3f9d85a86a1d36c8;
      end
      default: begin
        r384 = 64'h47b5481dbefa4fa4; r512 = 64'h5be0cd19137e2179;
        r256 = 64'h0eb72ddc81c52ca2; r224 = 64'h1112e6ad91d692a1;
      end
    endcase
    unique case (v)
      3'd0:    res = {32'd0, r384[31:0]};
      3'd1:    res = {32'd0, r512[63:32]};
      3'd2:    res = r384;
      3'd3:    res = r512;
      3'd4:    res = r256;
      default: res = r224;
    endcase
    return res;
  endfunction

  function automatic logic [3:0] word_count(input logic [2:0] v);
    logic [3:0] n;
    unique case (v)
      3'd0:    n = 4'd7;
      3'd1:    n = 4'd8;
      3'd2:    n = 4'd6;
      3'd3:    n = 4'd8;
      default: n = 4'd4;
    endcase
    return n;
  endfunction

  function automatic logic [63:0] k_word(input logic [6:0] i);
    logic [63:0] k;
    unique case (i)
      7'd0:  k = 64'h428a2f98d728ae22; 7'd1:  k = 64'h7137449123ef65cd;
      7'd2:  k = 64'hb5c0fbcfec4d3b2f; 7'd3:  k = 64'he9b5dba58189dbbc;
      7'd4:  k = 64'h3956c25bf348b538; 7'd5:  k = 64'h59f111f1b605d019;
      7'd6:  k = 64'h923f82a4af194f9b; 7'd7:  k = 64'hab1c5ed5da6d8118;
      7'd8:  k = 64'hd807aa98a3030242; 7'd9:  k = 64'h12835b0145706fbe;
      7'd10: k = 64'h243185be4ee4b28c; 7'd11: k = 64'h550c7dc3d5ffb4e2;
      7'd12: k = 64'h72be5d74f27b896f; 7'd13: k = 64'h80deb1fe3b1696b1;
      7'd14: k = 64'h9bdc06a725c71235; 7'd15: k = 64'hc19bf174cf692694;
      7'd16: k = 64'he49b69c19ef14ad2; 7'd17: k = 64'hefbe4786384f25e3;
      7'd18: k = 64'h0fc19dc68b8cd5b5; 7'd19: k = 64'h240ca1cc77ac9c65;
      7'd20: k = 64'h2de92c6f592b0275; 7'd21: k = 64'h4a7484aa6ea6e483;
      7'd22: k = 64'h5cb0a9dcbd41fbd4; 7'd23: k = 64'h76f988da831153b5;
      7'd24: k = 64'h983e5152ee66dfab; 7'd25: k = 64'ha831c66d2db43210;
      7'd26: k = 64'hb00327c898fb213f; 7'd27: k = 64'hbf597fc7beef0ee4;
      7'd28: k = 64'hc6e00bf33da88fc2; 7'd29: k = 64'hd5a79147930aa725;
      7'd30: k = 64'h06ca6351e003826f; 7'd31: k = 64'h142929670a0e6e70;
      7'd32: k = 64'h27b70a8546d22ffc; 7'd33: k = 64'h2e1b21385c26c926;
      7'd34: k = 64'h4d2c6dfc5ac42aed; 7'd35: k = 64'h53380d139d95b3df;
      7'd36: k = 64'h650a73548baf63de; 7'd37: k = 64'h766a0abb3c77b2a8;
      7'd38: k = 64'h81c2c92e47edaee6; 7'd39: k = 64'h92722c851482353b;
      7'd40: k = 64'ha2bfe8a14cf10364; 7'd41: k = 64'ha81a664bbc423001;
      7'd42: k = 64'hc24b8b70d0f89791; 7'd43: k = 64'hc76c51a30654be30;
      7'd44: k = 64'hd192e819d6ef5218; 7'd45: k = 64'hd69906245565a910;
      7'd46: k = 64'hf40e35855771202a; 7'd47: k = 64'h106aa07032bbd1b8;
      7'd48: k = 64'h19a4c116b8d2d0c8; 7'd49: k = 64'h1e376c085141ab53;
      7'd50: k = 64'h2748774cdf8eeb99; 7'd51: k = 64'h34b0bcb5e19b48a8;
      7'd52: k = 64'h391c0cb3c5c95a63; 7'd53: k = 64'h4ed8aa4ae3418acb;
      7'd54: k = 64'h5b9cca4f7763e373; 7'd55: k = 64'h682e6ff3d6b2b8a3;
      7'd56: k = 64'h748f82ee5defb2fc; 7'd57: k = 64'h78a5636f43172f60;
      7'd58: k = 64'h84c87814a1f0ab72; 7'd59: k = 64'h8cc702081a6439ec;
      7'd60: k = 64'h90befffa23631e28; 7'd61: k = 64'ha4506cebde82bde9;
      7'd62: k = 64'hbef9a3f7b2c67915; 7'd63: k = 64'hc67178f2e372532b;
      7'd64: k = 64'hca273eceea26619c; 7'd65: k = 64'hd186b8c721c0c207;
      7'd66: k = 64'heada7dd6cde0eb1e; 7'd67: k = 64'hf57d4f7fee6ed178;
      7'd68: k = 64'h06f067aa72176fba; 7'd69: k = 64'h0a637dc5a2c898a6;
      7'd70: k = 64'h113f9804bef90dae; 7'd71: k = 64'h1b710b35131c471b;
      7'd72: k = 64'h28db77f523047d84; 7'd73: k = 64'h32caab7b40c72493;
      7'd74: k = 64'h3c9ebe0a15c9bebc; 7'd75: k = 64'h431d67c49c100d4c;
      7'd76: k = 64'h4cc5d4becb3e42b6; 7'd77: k = 64'h597f299cfc657e2a;
      7'd78: k = 64'h5fcb6fab3ad6faec; 7'd79: k = 64'h6c44198c4a475817;
      default: k = 64'd0;
    endcase
    return k;
  endfunction

  function automatic logic [63:0] rr64(input logic [63:0] x, input int unsigned n);
    return (x >> n) | (x << (64 - n));
  endfunction

  function automatic logic [31:0] rr32(input logic [31:0] x, input int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic logic [63:0] big_s0(input logic [63:0] x, input logic wide);
    return wide ? (rr64(x, 28) ^ rr64(x, 34) ^ rr64(x, 39))
                : {32'd0, rr32(x[31:0], 2) ^ rr32(x[31:0], 13) ^ rr32(x[31:0], 22)};
  endfunction

  function automatic logic [63:0] big_s1(input logic [63:0] x, input logic wide);
    return wide ? (rr64(x, 14) ^ rr64(x, 18) ^ rr64(x, 41))
                : {32'd0, rr32(x[31:0], 6) ^ rr32(x[31:0], 11) ^ rr32(x[31:0], 25)};
  endfunction

  function automatic logic [63:0] sml_s0(input logic [63:0] x, input logic wide);
    return wide ? (rr64(x, 1) ^ rr64(x, 8) ^ (x >> 7))
                : {32'd0, rr32(x[31:0], 7) ^ rr32(x[31:0], 18) ^ (x[31:0] >> 3)};
  endfunction

  function automatic logic [63:0] sml_s1(input logic [63:0] x, input logic wide);
    return wide ? (rr64(x, 19) ^ rr64(x, 61) ^ (x >> 6))
                : {32'd0, rr32(x[31:0], 17) ^ rr32(x[31:0], 19) ^ (x[31:0] >> 10)};
  endfunction

  function automatic logic [63:0] fit(input logic [63:0] x, input logic wide);
    return wide ? x : {32'd0, x[31:0]};
  endfunction

endpackage
`default_nettype wire

>>> hw/rtl/sha2fh_ctrl.sv
`default_nettype none
module sha2fh_ctrl
  import sha2fh_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  input  wire logic action_i,
  input  wire logic out_stall_i,
  input  sts_t      sts_i,
  output cmd_t      cmd_o,
  output logic      in_stall_o,
  output logic      out_valid_o
);

  state_e state_q, state_d;
  state_e ret_q, ret_d;
  logic   len_q, len_d;
  logic   len_now;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      ret_q   <= ST_IDLE;
      len_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      ret_q   <= ret_d;
      len_q   <= len_d;
    end
  end

  assign len_now = len_q | sts_i.at_len;

  always_comb begin
    state_d     = state_q;
    ret_d       = ret_q;
    len_d       = len_q;
    cmd_o       = '0;
    cmd_o.sel   = SEL_MSG;
    in_stall_o  = 1'b1;
    out_valid_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.absorb = 1'b1;
          if (!action_i) begin
            cmd_o.count = 1'b1;
            ret_d       = ST_IDLE;
            if (sts_i.fill_last) state_d = ST_ROUND;
          end else begin
            cmd_o.sel = SEL_MARK;
            len_d     = 1'b0;
            ret_d     = ST_PAD;
            state_d   = sts_i.fill_last ? ST_ROUND : ST_PAD;
          end
        end
      end
      ST_PAD: begin
        cmd_o.absorb   = 1'b1;
        cmd_o.sel      = SEL_PAD;
        cmd_o.len_zone = len_now;
        len_d          = len_now;
        if (sts_i.fill_last) begin
          state_d = ST_ROUND;
          ret_d   = len_now ? ST_OUT : ST_PAD;
        end
      end
      ST_ROUND: begin
        cmd_o.round = 1'b1;
        if (sts_i.round_last) state_d = ST_FOLD;
      end
      ST_FOLD: begin
        cmd_o.fold = 1'b1;
        state_d    = ret_q;
      end
      ST_OUT: begin
        out_valid_o = 1'b1;
        if (!out_stall_i) begin
          cmd_o.out_adv = 1'b1;
          if (sts_i.out_last) begin
            cmd_o.restart = 1'b1;
            state_d       = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule
`default_nettype wire

>>> hw/rtl/sha2fh_dp.sv
`default_nettype none
module sha2fh_dp
  import sha2fh_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic [2:0]  variant_i,
  input  wire logic        cfg_restart_i,
  input  wire logic [7:0]  message_byte_i,
  input  cmd_t             cmd_i,
  output sts_t             sts_o,
  output logic [63:0]      digest_word_o,
  output logic [3:0]       word_bytes_o,
  output logic             last_word_o
);

  logic        wide;
  logic [63:0] chain_q [8];
  logic [63:0] work_q  [8];
  logic [63:0] w_q     [16];
  logic [55:0] acc_q;
  logic [6:0]  fill_q;
  logic [60:0] msg_q;
  logic [6:0]  rnd_q;
  logic [2:0]  ocnt_q;

  logic [6:0]  blk_last;
  logic [6:0]  pad_idx;
  logic [63:0] bitlen;
  logic [7:0]  pad_byte;
  logic [7:0]  in_byte;
  logic [63:0] new_word;
  logic        word_done;
  logic [63:0] k_cur;
  logic [63:0] t1, t2, sched;
  logic [3:0]  nwords;

  assign wide     = (variant_i != VarSha224) && (variant_i != VarSha256);
  assign blk_last = wide ? 7'd127 : 7'd63;
  assign pad_idx  = blk_last - fill_q;
  assign bitlen   = {msg_q, 3'b000};
  assign pad_byte = (cmd_i.len_zone && (pad_idx < 7'd8))
                    ? 8'(bitlen >> {pad_idx[2:0], 3'b000}) : 8'd0;

  always_comb begin
    unique case (cmd_i.sel)
      SEL_MARK: in_byte = PadMark;
      SEL_PAD:  in_byte = pad_byte;
      default:  in_byte = message_byte_i;
    endcase
  end

  assign new_word  = wide ? {acc_q, in_byte} : {32'd0, acc_q[23:0], in_byte};
  assign word_done = wide ? (fill_q[2:0] == 3'd7) : (fill_q[1:0] == 2'd3);

  assign k_cur = k_word(rnd_q);

  assign t1 = fit(work_q[7] + big_s1(work_q[4], wide)
                  + ((work_q[4] & work_q[5]) ^ (~work_q[4] & work_q[6]))
                  + (wide ? k_cur : {32'd0, k_cur[63:32]}) + w_q[0], wide);
  assign t2 = fit(big_s0(work_q[0], wide)
                  + ((work_q[0] & work_q[1]) ^ (work_q[0] & work_q[2])
                     ^ (work_q[1] & work_q[2])), wide);
  assign sched = fit(sml_s1(w_q[14], wide) + w_q[9] + sml_s0(w_q[1], wide) + w_q[0], wide);

  assign nwords = word_count(variant_i);

  assign sts_o.fill_last  = (fill_q == blk_last);
  assign sts_o.at_len     = (fill_q == (wide ? 7'd112 : 7'd56));
  assign sts_o.round_last = (rnd_q == (wide ? 7'd79 : 7'd63));
  assign sts_o.out_last   = ({1'b0, ocnt_q} == (nwords - 4'd1));

  always_comb begin
    digest_word_o = chain_q[ocnt_q];
    word_bytes_o  = wide ? 4'd8 : 4'd4;
    last_word_o   = sts_o.out_last;
    if ((variant_i == VarSha512224) && sts_o.out_last) begin
      digest_word_o = chain_q[ocnt_q] >> 32;
      word_bytes_o  = 4'd4;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 8; i++) chain_q[i] <= iv_word(VarSha256, 3'(i));
      fill_q <= '0;
      msg_q  <= '0;
      rnd_q  <= '0;
      ocnt_q <= '0;
    end else begin
      if (cfg_restart_i || cmd_i.restart) begin
        for (int i = 0; i < 8; i++) chain_q[i] <= iv_word(variant_i, 3'(i));
        fill_q <= '0;
        msg_q  <= '0;
      end else begin
        if (cmd_i.absorb) fill_q <= sts_o.fill_last ? 7'd0 : fill_q + 7'd1;
        if (cmd_i.count)  msg_q  <= msg_q + 61'd1;
        if (cmd_i.fold) begin
          for (int i = 0; i < 8; i++) chain_q[i] <= fit(chain_q[i] + work_q[i], wide);
        end
      end
      if (cmd_i.absorb && sts_o.fill_last) rnd_q <= '0;
      else if (cmd_i.round) rnd_q <= rnd_q + 7'd1;
      if (cmd_i.out_adv) ocnt_q <= sts_o.out_last ? 3'd0 : ocnt_q + 3'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.absorb) begin
      acc_q <= new_word[55:0];
      if (word_done) begin
        for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
        w_q[15] <= new_word;
      end
      if (sts_o.fill_last) begin
        for (int i = 0; i < 8; i++) work_q[i] <= chain_q[i];
      end
    end else if (cmd_i.round) begin
      for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
      w_q[15] <= sched;
      for (int i = 1; i < 8; i++) work_q[i] <= work_q[i-1];
      work_q[4] <= fit(work_q[3] + t1, wide);
      work_q[0] <= fit(t1 + t2, wide);
    end
  end

endmodule
`default_nettype wire

>>> hw/rtl/sha2_family_hash.sv
// SHA-2 hash engine for SHA-224, SHA-256, SHA-384, SHA-512, SHA-512/256 and
// SHA-512/224, selected by the variant register at APB address 0.
// Input items carry an action and a byte: action 0 appends the byte, action 1
// finishes the message. Results leave on the output channel as digest words,
// most significant first, with word_bytes and last_word alongside.
// An append absorbs its byte; the byte that fills a block also starts a run
// of 64 or 80 compression rounds, then a fold into the chaining value.
// The round loop of one round per cycle sets the rate.
// A finish streams the padding bytes at one per cycle, compresses one or two
// blocks, then presents 4 to 8 words, one per cycle while the receiver does
// not stall. A stalled word holds; no input is taken until the last word goes.
// Reset selects SHA-256 with its initial values and an empty message.
// Writing the variant register restarts the hash; write it only while idle.
`default_nettype none
module sha2_family_hash
  import sha2fh_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic        action_i,
  input  wire logic [7:0]  message_byte_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [63:0]      digest_word_o,
  output logic [3:0]       word_bytes_o,
  output logic             last_word_o,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  logic [2:0] variant_q;
  logic [2:0] eff_variant;
  logic       cfg_we;
  cmd_t       cmd;
  sts_t       sts;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && !paddr[2] && (paddr[1:0] == 2'b00);
  assign prdata = (paddr == 3'd0) ? {29'd0, variant_q} : 32'd0;
  assign eff_variant = (variant_q > VarLast) ? VarLast : variant_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      variant_q <= VarSha256;
    end else if (cfg_we) begin
      variant_q <= pwdata[2:0];
    end
  end

  sha2fh_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .action_i    (action_i),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o)
  );

  sha2fh_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .variant_i      (cfg_we ? ((pwdata[2:0] > VarLast) ? VarLast : pwdata[2:0]) : eff_variant),
    .cfg_restart_i  (cfg_we),
    .message_byte_i (message_byte_i),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .digest_word_o  (digest_word_o),
    .word_bytes_o   (word_bytes_o),
    .last_word_o    (last_word_o)
  );

endmodule
`default_nettype wire

>>> hw/rtl/sha2fh_chk.sv
`default_nettype none
`include "sha2_family_hash_assert.svh"
module sha2fh_chk (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_stall_o,
  input wire logic        out_valid_o,
  input wire logic        out_stall_i,
  input wire logic [3:0]  word_bytes_o,
  input wire logic        last_word_o
);

  `SHA2FH_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o)
  `SHA2FH_ASSERT_NOW(a_no_in_while_out, clk_i, rst_ni, out_valid_o, in_stall_o)
  `SHA2FH_ASSERT_NEXT(a_end_of_digest, clk_i, rst_ni, out_valid_o && !out_stall_i && last_word_o, !out_valid_o)
  `SHA2FH_ASSERT_NOW(a_bytes_legal, clk_i, rst_ni, out_valid_o, word_bytes_o == 4'd4 || word_bytes_o == 4'd8)

endmodule

bind sha2_family_hash sha2fh_chk u_sha2fh_chk (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_stall_o   (in_stall_o),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .word_bytes_o (word_bytes_o),
  .last_word_o  (last_word_o)
);
`default_nettype wire

>>> tb/tb.sv
`default_nettype none
module tb;
  import sha2fh_pkg::*;

  localparam int unsigned CycleLimit = 2_000_000;
  localparam int unsigned DrainCycles = 400;

  localparam logic [2:0] RegVariant = 3'd0;
  localparam logic ActAppend = 1'b0;
  localparam logic ActFinish = 1'b1;

  typedef struct {
    logic [63:0] word;
    logic [3:0]  width;
    logic        last;
  } digest_word_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic        action_i = ActAppend;
  logic [7:0]  message_byte_i = 8'd0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [63:0] digest_word_o;
  logic [3:0]  word_bytes_o;
  logic        last_word_o;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = 3'd0;
  logic [31:0] pwdata = 32'd0;
  logic [31:0] prdata;
  logic        pready;

  sha2_family_hash dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  const logic [63:0] RoundK [80] = '{
    64'h428a2f98d728ae22, 64'h7137449123ef65cd, 64'hb5c0fbcfec4d3b2f, 64'he9b5dba58189dbbc,
    64'h3956c25bf348b538, 64'h59f111f1b605d019, 64'h923f82a4af194f9b, 64'hab1c5ed5da6d8118,
    64'hd807aa98a3030242, 64'h12835b0145706fbe, 64'h243185be4ee4b28c, 64'h550c7dc3d5ffb4e2,
    64'h72be5d74f27b896f, 64'h80deb1fe3b1696b1, 64'h9bdc06a725c71235, 64'hc19bf174cf692694,
    64'he49b69c19ef14ad2, 64'hefbe4786384f25e3, 64'h0fc19dc68b8cd5b5, 64'h240ca1cc77ac9c65,
    64'h2de92c6f592b0275, 64'h4a7484aa6ea6e483, 64'h5cb0a9dcbd41fbd4, 64'h76f988da831153b5,
    64'h983e5152ee66dfab, 64'ha831c66d2db43210, 64'hb00327c898fb213f, 64'hbf597fc7beef0ee4,
    64'hc6e00bf33da88fc2, 64'hd5a79147930aa725, 64'h06ca6351e003826f, 64'h142929670a0e6e70,
    64'h27b70a8546d22ffc, 64'h2e1b21385c26c926, 64'h4d2c6dfc5ac42aed, 64'h53380d139d95b3df,
    64'h650a73548baf63de, 64'h766a0abb3c77b2a8, 64'h81c2c92e47edaee6, 64'h92722c851482353b,
    64'ha2bfe8a14cf10364, 64'ha81a664bbc423001, 64'hc24b8b70d0f89791, 64'hc76c51a30654be30,
    64'hd192e819d6ef5218, 64'hd69906245565a910, 64'hf40e35855771202a, 64'h106aa07032bbd1b8,
    64'h19a4c116b8d2d0c8, 64'h1e376c085141ab53, 64'h2748774cdf8eeb99, 64'h34b0bcb5e19b48a8,
    64'h391c0cb3c5c95a63, 64'h4ed8aa4ae3418acb, 64'h5b9cca4f7763e373, 64'h682e6ff3d6b2b8a3,
    64'h748f82ee5defb2fc, 64'h78a5636f43172f60, 64'h84c87814a1f0ab72, 64'h8cc702081a6439ec,
    64'h90befffa23631e28, 64'ha4506cebde82bde9, 64'hbef9a3f7b2c67915, 64'hc67178f2e372532b,
    64'hca273eceea26619c, 64'hd186b8c721c0c207, 64'heada7dd6cde0eb1e, 64'hf57d4f7fee6ed178,
    64'h06f067aa72176fba, 64'h0a637dc5a2c898a6, 64'h113f9804bef90dae, 64'h1b710b35131c471b,
    64'h28db77f523047d84, 64'h32caab7b40c72493, 64'h3c9ebe0a15c9bebc, 64'h431d67c49c100d4c,
    64'h4cc5d4becb3e42b6, 64'h597f299cfc657e2a, 64'h5fcb6fab3ad6faec, 64'h6c44198c4a475817
  };

  // Rows for SHA-384, SHA-512, SHA-512/256 and SHA-512/224. SHA-224 takes the
  // low halves of the first row and SHA-256 the high halves of the second.
  const logic [63:0] InitRows [4][8] = '{
    '{64'hcbbb9d5dc1059ed8, 64'h629a292a367cd507, 64'h9159015a3070dd17, 64'h152fecd8f70e5939,
      64'h67332667ffc00b31, 64'h8eb44a8768581511, 64'hdb0c2e0d64f98fa7, 64'h47b5481dbefa4fa4},
    '{64'h6a09e667f3bcc908, 64'hbb67ae8584caa73b, 64'h3c6ef372fe94f82b, 64'ha54ff53a5f1d36f1,
      64'h510e527fade682d1, 64'h9b05688c2b3e6c1f, 64'h1f83d9abfb41bd6b, 64'h5be0cd19137e2179},
    '{64'h22312194fc2bf72c, 64'h9f555fa3c84c64c2, 64'h2393b86b6f53b151, 64'h963877195940eabd,
      64'h96283ee2a88effe3, 64'hbe5e1e2553863992, 64'h2b0199fc2c85b8aa, 64'h0eb72ddc81c52ca2},
    '{64'h8c3d37c819544da2, 64'h73e1996689dcd4d6, 64'h1dfab7ae32ff9c82, 64'h679dd514582f9fcf,
      64'h0f6d2b697bd44da8, 64'h77e36f7304c48942, 64'h3f9d85a86a1d36c8, 64'h1112e6ad91d692a1}
  };

  function automatic logic [31:0] ror32(logic [31:0] x, int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic logic [63:0] ror64(logic [63:0] x, int unsigned n);
    return (x >> n) | (x << (64 - n));
  endfunction

  class digest_scoreboard;
    logic [63:0]  chain [8];
    logic [7:0]   block [128];
    int unsigned  fill;
    logic [60:0]  msg_len;
    logic [2:0]   variant;
    digest_word_t digest_q [$];
    int unsigned  errors;

    function int unsigned mode();
      return (variant > VarLast) ? 5 : int'(variant);
    endfunction

    function bit wide();
      return mode() >= 2;
    endfunction

    function void restart();
      for (int i = 0; i < 8; i++) begin
        case (mode())
          0: chain[i] = {32'd0, InitRows[0][i][31:0]};
          1: chain[i] = {32'd0, InitRows[1][i][63:32]};
          default: chain[i] = InitRows[mode() - 2][i];
        endcase
      end
      fill = 0;
      msg_len = '0;
    endfunction

    function void set_variant(logic [2:0] v);
      variant = v;
      restart();
    endfunction

    function void compress_narrow();
      logic [31:0] w [64];
      logic [31:0] s [8];
      logic [31:0] t1;
      logic [31:0] t2;
      for (int i = 0; i < 16; i++)
        w[i] = {block[4*i], block[4*i+1], block[4*i+2], block[4*i+3]};
      for (int i = 16; i < 64; i++)
        w[i] = w[i-16] + (ror32(w[i-15], 7) ^ ror32(w[i-15], 18) ^ (w[i-15] >> 3)) + w[i-7]
             + (ror32(w[i-2], 17) ^ ror32(w[i-2], 19) ^ (w[i-2] >> 10));
      for (int i = 0; i < 8; i++) s[i] = chain[i][31:0];
      for (int i = 0; i < 64; i++) begin
        t1 = s[7] + (ror32(s[4], 6) ^ ror32(s[4], 11) ^ ror32(s[4], 25))
           + ((s[4] & s[5]) ^ (~s[4] & s[6])) + RoundK[i][63:32] + w[i];
        t2 = (ror32(s[0], 2) ^ ror32(s[0], 13) ^ ror32(s[0], 22))
           + ((s[0] & s[1]) ^ (s[0] & s[2]) ^ (s[1] & s[2]));
        for (int j = 7; j > 0; j--) s[j] = s[j-1];
        s[4] += t1;
        s[0] = t1 + t2;
      end
      for (int i = 0; i < 8; i++) chain[i] = {32'd0, chain[i][31:0] + s[i]};
    endfunction

    function void compress_wide();
      logic [63:0] w [80];
      logic [63:0] s [8];
      logic [63:0] t1;
      logic [63:0] t2;
      for (int i = 0; i < 16; i++)
        for (int b = 0; b < 8; b++) w[i] = {w[i][55:0], block[8*i+b]};
      for (int i = 16; i < 80; i++)
        w[i] = w[i-16] + (ror64(w[i-15], 1) ^ ror64(w[i-15], 8) ^ (w[i-15] >> 7)) + w[i-7]
             + (ror64(w[i-2], 19) ^ ror64(w[i-2], 61) ^ (w[i-2] >> 6));
      s = chain;
      for (int i = 0; i < 80; i++) begin
        t1 = s[7] + (ror64(s[4], 14) ^ ror64(s[4], 18) ^ ror64(s[4], 41))
           + ((s[4] & s[5]) ^ (~s[4] & s[6])) + RoundK[i] + w[i];
        t2 = (ror64(s[0], 28) ^ ror64(s[0], 34) ^ ror64(s[0], 39))
           + ((s[0] & s[1]) ^ (s[0] & s[2]) ^ (s[1] & s[2]));
        for (int j = 7; j > 0; j--) s[j] = s[j-1];
        s[4] += t1;
        s[0] = t1 + t2;
      end
      for (int i = 0; i < 8; i++) chain[i] += s[i];
    endfunction

    function void absorb(logic [7:0] b);
      block[fill] = b;
      fill++;
      if (fill == (wide() ? 128 : 64)) begin
        if (wide()) compress_wide();
        else compress_narrow();
        fill = 0;
      end
    endfunction

    function void note_item(logic act, logic [7:0] b);
      int unsigned  len_bytes;
      int unsigned  count;
      logic [63:0]  bit_len;
      digest_word_t dw;
      if (act == ActAppend) begin
        absorb(b);
        msg_len++;
        return;
      end
      len_bytes = wide() ? 16 : 8;
      bit_len = {msg_len, 3'b000};
      absorb(PadMark);
      while (fill != (wide() ? 128 : 64) - len_bytes) absorb(8'h00);
      for (int k = len_bytes - 1; k >= 0; k--)
        absorb(k >= 8 ? 8'h00 : bit_len[8*k +: 8]);
      case (mode())
        0: count = 7;
        1: count = 8;
        2: count = 6;
        3: count = 8;
        default: count = 4;
      endcase
      for (int k = 0; k < count; k++) begin
        dw.word = chain[k];
        dw.width = wide() ? 4'd8 : 4'd4;
        dw.last = (k == count - 1);
        if (mode() == 5 && dw.last) begin
          dw.word = chain[k] >> 32;
          dw.width = 4'd4;
        end
        digest_q.push_back(dw);
      end
      restart();
    endfunction

    function void check_word(logic [63:0] word, logic [3:0] width, logic last);
      digest_word_t dw;
      if (digest_q.size() == 0) begin
        $error("digest word %h arrived with none expected", word);
        errors++;
        return;
      end
      dw = digest_q.pop_front();
      if (word !== dw.word) begin
        $error("digest_word expected %h got %h", dw.word, word);
        errors++;
      end
      if (width !== dw.width) begin
        $error("word_bytes expected %0d got %0d", dw.width, width);
        errors++;
      end
      if (last !== dw.last) begin
        $error("last_word expected %0d got %0d", dw.last, last);
        errors++;
      end
    endfunction
  endclass

  digest_scoreboard sb = new();
  int unsigned cycles = 0;
  int unsigned stall_left = 0;
  int unsigned free_left = 0;

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Receiver stalls: runs of random stall broken by stall-free stretches.
  always @(posedge clk_i) begin
    if (free_left > 0) begin
      free_left <= free_left - 1;
      out_stall_i <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall_i <= 1'b1;
    end else if ($urandom_range(0, 3) == 0) begin
      free_left <= $urandom_range(5, 60);
      out_stall_i <= 1'b0;
    end else begin
      stall_left <= pick_gap();
      out_stall_i <= 1'b0;
    end
  end

  // Both channels are sampled mid-cycle, where nothing changes until the edge.
  always @(negedge clk_i) begin
    if (rst_ni && in_valid_i && !in_stall_o) sb.note_item(action_i, message_byte_i);
    if (rst_ni && out_valid_o && !out_stall_i)
      sb.check_word(digest_word_o, word_bytes_o, last_word_o);
  end

  task automatic send_item(logic act, logic [7:0] b);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    action_i <= act;
    message_byte_i <= b;
    do @(negedge clk_i); while (in_stall_o);
    @(posedge clk_i);
  endtask

  task automatic send_message(int unsigned len);
    for (int i = 0; i < len; i++) send_item(ActAppend, 8'($urandom));
    send_item(ActFinish, 8'($urandom));
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.digest_q.size() > 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_variant(logic [2:0] v);
    drain();
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= RegVariant;
    pwdata <= {29'd0, v};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    sb.set_variant(v);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  initial begin
    int unsigned sent;
    int unsigned len;
    int unsigned r;
    sb.set_variant(VarSha256);
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Empty message, the extreme byte values, and a finish straight after one.
    send_item(ActFinish, 8'hff);
    send_item(ActAppend, 8'h00);
    send_item(ActAppend, 8'hff);
    send_item(ActFinish, 8'h00);
    send_item(ActFinish, 8'h00);
    send_item(ActAppend, 8'h61);
    send_item(ActAppend, 8'h62);
    send_item(ActAppend, 8'h63);
    send_item(ActFinish, 8'h00);
    // Out-of-range variants behave as SHA-512/224.
    write_variant(3'd7);
    send_item(ActFinish, 8'h00);
    write_variant(VarSha224);
    send_item(ActAppend, 8'h80);
    send_item(ActFinish, 8'h00);

    sent = 0;
    for (int ph = 0; sent < 500; ph++) begin
      write_variant(ph < 8 ? 3'(ph) : 3'($urandom_range(0, 7)));
      for (int m = 0; m < 6 && sent < 500; m++) begin
        r = $urandom_range(0, 99);
        if (r < 60) len = $urandom_range(0, 20);
        else if (r < 90) len = $urandom_range(0, 1) ? $urandom_range(54, 65)
                                                    : $urandom_range(110, 129);
        else len = $urandom_range(130, 260);
        send_message(len);
        sent += len + 1;
      end
    end
    drain();
    if (sb.errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule
`default_nettype wire
